// ===== rtl/signed_binary_to_decimal_ascii_core_macros.svh =====
// Assertion macros for the signed binary to decimal ASCII core.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define SBDC_CHECK(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Implication checked outside reset.
`define SBDC_CHECK_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sbdc_pkg.sv =====
// Package: constants and types shared by the decimal ASCII converter.
`timescale 1ns / 1ps
package sbdc_pkg;
   localparam int ValueWidth = 32;
   localparam int DigitCount = 10;
   localparam int CharWidth  = 7;
   localparam int BitCntWidth = $clog2(ValueWidth);
   localparam int DigCntWidth = $clog2(DigitCount + 1);

   localparam logic [CharWidth-1:0] CharZero  = 7'h30;
   localparam logic [CharWidth-1:0] CharNine  = 7'h39;
   localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

   typedef struct packed {
      logic clear;
      logic conv;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SIGN = 5'b00100,
      ST_SKIP = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;
endpackage

// ===== rtl/sbdc_cell.sv =====
// One BCD digit cell: add-3 and shift during conversion, digit shift during output.
`timescale 1ns / 1ps
module sbdc_cell (
   input  logic                  clock,
   input  sbdc_pkg::cell_ctrl_type ctrl,
   input  logic                  bit_in,
   input  logic [3:0]            lower_digit,
   output logic                  bit_out,
   output logic [3:0]            digit_q
);
   import sbdc_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   assign adj     = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign bit_out = adj[3];
   assign digit_q = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.conv) begin
         digit_in = {adj[2:0], bit_in};
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end
endmodule

// ===== rtl/signed_binary_to_decimal_ascii_core.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//  channel  | direction | ports
//  request  | in        | req_valid, req_stall, req_value[31:0] signed
//  response | out       | rsp_valid, rsp_stall, rsp_digit_char[6:0], rsp_last
//
// A request is loaded, then shifted through the chain of ten BCD cells (one
// magnitude bit per cycle); the sign is then sent if the value is negative, leading
// zeros are skipped, and the digits are sent one after another.
// The next request is taken once the last character sits in the output register.
// Reset clears the control state only. While rsp_valid is high, rsp_stall holds the
// output register and the sign and digit output until it drops; conversion and zero skip do not wait.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_core_macros.svh"
module signed_binary_to_decimal_ascii_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sbdc_pkg::ValueWidth-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sbdc_pkg::CharWidth-1:0]      rsp_digit_char,
   output logic                                rsp_last
);
   import sbdc_pkg::*;

   state_type                state_ff, state_in;
   logic [ValueWidth-1:0]    mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [BitCntWidth-1:0]   bitcnt_ff, bitcnt_in;
   logic [DigCntWidth-1:0]   digcnt_ff, digcnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]     rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            ctrl;
   logic                     carry [0:DigitCount];
   logic [3:0]               digit [0:DigitCount-1];
   logic [3:0]               top_digit;
   logic                     slot_free;
   logic                     load;
   logic                     chain_ovf;
   logic                     char_ok;
   logic                     digit_phase;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign slot_free      = !rsp_valid_ff || !rsp_stall;
   assign top_digit      = digit[DigitCount-1];
   assign carry[0]       = mag_ff[ValueWidth-1];

   for (genvar i = 0; i < DigitCount; i++) begin : g_cell
      logic [3:0] lower;
      if (i == 0) begin : g_first
         assign lower = 4'd0;
      end else begin : g_rest
         assign lower = digit[i-1];
      end
      sbdc_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .bit_in      (carry[i]),
         .lower_digit (lower),
         .bit_out     (carry[i+1]),
         .digit_q     (digit[i])
      );
   end

   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      bitcnt_in   = bitcnt_ff;
      digcnt_in   = digcnt_ff;
      ctrl        = '0;
      load        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in     = req_value[ValueWidth-1];
               mag_in     = req_value[ValueWidth-1] ? (~req_value + ValueWidth'(1))
                                                    : req_value;
               bitcnt_in  = '0;
               ctrl.clear = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            ctrl.conv = 1'b1;
            mag_in    = {mag_ff[ValueWidth-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + BitCntWidth'(1);
            if (bitcnt_ff == BitCntWidth'(ValueWidth - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            digcnt_in = DigCntWidth'(DigitCount);
            if (!neg_ff) begin
               state_in = ST_SKIP;
            end else if (slot_free) begin
               load        = 1'b1;
               rsp_char_in = CharMinus;
               rsp_last_in = 1'b0;
               state_in    = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && digcnt_ff > DigCntWidth'(1)) begin
               ctrl.shift = 1'b1;
               digcnt_in  = digcnt_ff - DigCntWidth'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_char_in = CharZero + {3'b000, top_digit};
               rsp_last_in = (digcnt_ff == DigCntWidth'(1));
               ctrl.shift  = 1'b1;
               digcnt_in   = digcnt_ff - DigCntWidth'(1);
               if (digcnt_ff == DigCntWidth'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bitcnt_ff   <= bitcnt_in;
      digcnt_ff   <= digcnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign chain_ovf   = (state_ff == ST_CONV) && carry[DigitCount];
   assign char_ok     = (rsp_char_ff == CharMinus) ||
                        (rsp_char_ff >= CharZero && rsp_char_ff <= CharNine);
   assign digit_phase = (state_ff == ST_SKIP) || (state_ff == ST_EMIT);

   `SBDC_CHECK(a_no_chain_overflow, !chain_ovf, "BCD chain overflow")
   `SBDC_CHECK_IMPL(a_char_legal, rsp_valid_ff, char_ok, "illegal character")
   `SBDC_CHECK_IMPL(a_digcnt_live, digit_phase, digcnt_ff != '0, "digit count ran out")
endmodule

// ===== tb/testbench.sv =====
// Testbench: directed table and random signed values checked against a decimal text predictor.
`timescale 1ns / 1ps
module testbench;
   import sbdc_pkg::*;

   typedef struct packed {
      logic [CharWidth-1:0] code;
      logic                 last;
   } ascii_char_type;

   localparam int DirCount    = 19;
   localparam int RandCount   = 131;
   localparam int CycleLimit  = 1000000;
   localparam int DrainCycles = 60;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [ValueWidth-1:0] req_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [CharWidth-1:0]         rsp_digit_char;
   logic                         rsp_last;

   ascii_char_type pending_chars[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // empty text: expected characters come from the predictor
   int dir_values[DirCount] = '{
      0, 1, -1, 9, 10, -10, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
      999999999, 1000000000, -1000000000, 32'h55555555, 32'hAAAAAAAA,
      12345, -987654321, 99, 100, -5
   };
   string dir_texts[DirCount] = '{
      "0", "1", "-1", "9", "10", "", "2147483647", "-2147483648", "-2147483647",
      "", "1000000000", "", "", "",
      "", "", "", "", "-5"
   };

   signed_binary_to_decimal_ascii_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always #4 clock = ~clock;

   function automatic void push_decimal_chars(input logic [ValueWidth-1:0] value);
      logic                  negative;
      logic [ValueWidth-1:0] mag;
      logic [3:0]            digs[DigitCount];
      int                    nd;
      int                    i;
      negative = value[ValueWidth-1];
      mag = negative ? (~value + 32'd1) : value;
      nd = 0;
      do begin
         digs[nd] = 4'(mag % 32'd10);
         nd++;
         mag = mag / 32'd10;
      end while (mag != 0 && nd < DigitCount);
      if (negative)
         pending_chars.push_back('{CharMinus, 1'b0});
      for (i = nd - 1; i >= 0; i--)
         pending_chars.push_back('{CharZero + 7'(digs[i]), i == 0});
   endfunction

   function automatic void push_text(input string text);
      byte ch;
      int  i;
      for (i = 0; i < text.len(); i++) begin
         ch = text[i];
         pending_chars.push_back('{ch[6:0], i == text.len() - 1});
      end
   endfunction

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(99, 0);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 96) return $urandom_range(15, 4);
      return $urandom_range(80, 30);
   endfunction

   function automatic logic [ValueWidth-1:0] rand_value();
      int                    r;
      int                    nd;
      longint                lo;
      longint                hi;
      logic [ValueWidth-1:0] mag;
      r = $urandom_range(99, 0);
      if (r < 30) return $urandom;
      if (r < 40) return $urandom_range(20, 0) - 10;
      if (r < 50) begin
         mag = $urandom_range(15, 0);
         return $urandom_range(1, 0) ? 32'h80000000 + mag : 32'h7FFFFFFF - mag;
      end
      nd = $urandom_range(DigitCount, 1);
      lo = 1;
      repeat (nd - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'd2147483647) hi = 64'd2147483647;
      mag = $urandom_range(32'(hi), 32'(lo));
      return $urandom_range(1, 0) ? -mag : mag;
   endfunction

   function automatic void note_mismatch(input string msg);
      if (mismatch_count < 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endfunction

   task automatic send_value(input logic [ValueWidth-1:0] value, input string text,
                             input int gap);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (text.len() == 0)
         push_decimal_chars(value);
      else
         push_text(text);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int i;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < DirCount; i++)
         send_value(dir_values[i], dir_texts[i], gap_cycles());
      for (i = 0; i < RandCount; i++) begin
         if (i == RandCount / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_chars.size() != 0) @(posedge clock);
         end
         // back-to-back stretch
         send_value(rand_value(), "", (i >= 100 && i < 130) ? 0 : gap_cycles());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("** signed_binary_to_decimal_ascii_core: PASSED **");
      else
         $display("** signed_binary_to_decimal_ascii_core: FAILED **");
      $finish;
   end

   initial begin
      int run;
      int hold;
      int r;
      rsp_stall <= 1'b0;
      forever begin
         r = $urandom_range(99, 0);
         run = (r < 10) ? $urandom_range(300, 100) : $urandom_range(6, 1);
         repeat (run) @(posedge clock);
         r = $urandom_range(99, 0);
         hold = (r < 75) ? $urandom_range(3, 1) :
                (r < 95) ? $urandom_range(20, 4) : $urandom_range(100, 30);
         rsp_stall <= 1'b1;
         repeat (hold) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    rsp_digit_char, rsp_last));
         end else begin
            want = pending_chars.pop_front();
            if (want.code !== rsp_digit_char || want.last !== rsp_last)
               note_mismatch($sformatf("char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                                       want.code, rsp_digit_char, want.last, rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** signed_binary_to_decimal_ascii_core: FAILED **");
         $finish;
      end
   end
endmodule
